// ===== rtl/core/tmc_pkg.sv =====
package tmc_pkg;

  localparam int WordBits    = 32;
  localparam int FracBits    = 16;
  localparam int MulBits     = 34;
  localparam int ProdBits    = 2 * MulBits;
  localparam int RotShift    = 30 - FracBits;
  localparam int SqrtSteps   = 32;
  localparam int DivSteps    = 62;
  localparam int CordicSteps = 30;
  localparam int RotProducts = 12;
  localparam int MacSteps    = 64;
  localparam int AngSteps    = 3;
  localparam int Axes        = 3;
  localparam int Elems       = 16;

  typedef logic signed [WordBits-1:0] word_t;

  localparam word_t WordMax = 32'sh7FFF_FFFF;
  localparam word_t WordMin = 32'sh8000_0000;
  localparam word_t WordOne = 32'sd65536;

  localparam logic signed [35:0] PiQ30     = 36'sd3373259426;
  localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;
  localparam logic signed [35:0] TwoPiQ30  = 36'sd6746518852;
  localparam logic signed [33:0] CordicK   = 34'sd652032874;
  localparam logic signed [33:0] Q30One    = 34'sd1073741824;
  localparam logic signed [32:0] NormLimit = 33'sd1073741824;

  typedef enum logic [2:0] {
    OP_IDENT = 3'd0,
    OP_TRANS = 3'd1,
    OP_SCALE = 3'd2,
    OP_ROT   = 3'd3,
    OP_READ  = 3'd4,
    OP_LOAD  = 3'd5,
    OP_MULT  = 3'd6,
    OP_NONE  = 3'd7
  } op_e;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] arg_x;
    logic signed [31:0] arg_y;
    logic signed [31:0] arg_z;
    logic signed [19:0] angle;
    logic [3:0]         load_index;
    logic signed [31:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         element_index;
    logic signed [31:0] element_value;
    logic               last;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_NORM, S_SQ_MUL, S_SQ_ACC, S_SQRT_INIT, S_SQRT,
    S_DIV_INIT, S_DIV, S_DIV_DONE, S_ANG, S_CORDIC, S_RP_MUL, S_RP_SAVE,
    S_T_ROT, S_MAC_MUL, S_MAC_RND, S_MAC_ACC, S_COMMIT, S_READ
  } state_e;

  typedef enum logic [4:0] {
    DP_NONE, DP_LATCH, DP_IDENT, DP_LOAD_OP, DP_T_TRANS, DP_T_SCALE,
    DP_T_OPND, DP_NORM, DP_SQ_MUL, DP_SQ_ACC, DP_SQRT_INIT, DP_SQRT_STEP,
    DP_DIV_INIT, DP_DIV_STEP, DP_DIV_DONE, DP_ANG, DP_CORDIC, DP_RP_MUL,
    DP_RP_SAVE, DP_T_ROT, DP_MAC_MUL, DP_MAC_RND, DP_MAC_ACC, DP_COMMIT,
    DP_OUT
  } dp_act_e;

  typedef struct packed {
    dp_act_e    act;
    logic [5:0] cnt;
    logic [1:0] axis;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       axis_zero;
    logic       norm_done;
    logic       out_free;
  } dp_sts_t;

  function automatic logic [29:0] atan_q30(logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:    r = 30'd843314857;
      5'd1:    r = 30'd497837829;
      5'd2:    r = 30'd263043837;
      5'd3:    r = 30'd133525159;
      5'd4:    r = 30'd67021687;
      5'd5:    r = 30'd33543516;
      5'd6:    r = 30'd16775851;
      5'd7:    r = 30'd8388437;
      5'd8:    r = 30'd4194283;
      5'd9:    r = 30'd2097149;
      default: r = 30'd1 << (5'd30 - i);
    endcase
    return r;
  endfunction

  function automatic word_t wmul_round(logic signed [ProdBits-1:0] p);
    logic                neg;
    logic [ProdBits-1:0] mag;
    logic [ProdBits-1:0] q;
    logic [ProdBits-1:0] lim;
    word_t               r;
    neg = p[ProdBits-1];
    mag = neg ? (~p + 1'b1) : p;
    q   = (mag + (ProdBits'(1) << (FracBits - 1))) >> FracBits;
    lim = neg ? ProdBits'(64'd2147483648) : ProdBits'(64'd2147483647);
    if (q > lim) begin
      r = neg ? WordMin : WordMax;
    end else if (neg) begin
      r = word_t'(~q[WordBits-1:0] + 1'b1);
    end else begin
      r = word_t'(q[WordBits-1:0]);
    end
    return r;
  endfunction

  function automatic word_t wadd_sat(word_t a, word_t b);
    logic signed [WordBits:0] s;
    word_t                    r;
    s = {a[WordBits-1], a} + {b[WordBits-1], b};
    if (s[WordBits] != s[WordBits-1]) begin
      r = s[WordBits] ? WordMin : WordMax;
    end else begin
      r = s[WordBits-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/tmc_ctrl.sv =====
module tmc_ctrl import tmc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e     state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic [1:0] axis_q, axis_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      axis_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      axis_q  <= axis_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    axis_d  = axis_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        cnt_d  = '0;
        axis_d = '0;
        case (op_e'(sts_i.op))
          OP_TRANS, OP_SCALE, OP_MULT: state_d = S_MAC_MUL;
          OP_READ: state_d = S_READ;
          OP_ROT:  state_d = sts_i.axis_zero ? S_IDLE : S_NORM;
          default: state_d = S_IDLE;
        endcase
      end
      S_NORM: begin
        if (sts_i.norm_done) begin
          state_d = S_SQ_MUL;
        end
      end
      S_SQ_MUL: state_d = S_SQ_ACC;
      S_SQ_ACC: begin
        if (cnt_q == 6'(Axes - 1)) begin
          state_d = S_SQRT_INIT;
        end else begin
          cnt_d   = cnt_q + 6'd1;
          state_d = S_SQ_MUL;
        end
      end
      S_SQRT_INIT: begin
        cnt_d   = '0;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        if (cnt_q == 6'(SqrtSteps - 1)) begin
          axis_d  = '0;
          state_d = S_DIV_INIT;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      S_DIV_INIT: begin
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (cnt_q == 6'(DivSteps - 1)) begin
          state_d = S_DIV_DONE;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      S_DIV_DONE: begin
        if (axis_q == 2'(Axes - 1)) begin
          cnt_d   = '0;
          state_d = S_ANG;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = S_DIV_INIT;
        end
      end
      S_ANG: begin
        if (cnt_q == 6'(AngSteps - 1)) begin
          cnt_d   = '0;
          state_d = S_CORDIC;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      S_CORDIC: begin
        if (cnt_q == 6'(CordicSteps - 1)) begin
          cnt_d   = '0;
          state_d = S_RP_MUL;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      S_RP_MUL: state_d = S_RP_SAVE;
      S_RP_SAVE: begin
        if (cnt_q == 6'(RotProducts - 1)) begin
          state_d = S_T_ROT;
        end else begin
          cnt_d   = cnt_q + 6'd1;
          state_d = S_RP_MUL;
        end
      end
      S_T_ROT: begin
        cnt_d   = '0;
        state_d = S_MAC_MUL;
      end
      S_MAC_MUL: state_d = S_MAC_RND;
      S_MAC_RND: state_d = S_MAC_ACC;
      S_MAC_ACC: begin
        if (cnt_q == 6'(MacSteps - 1)) begin
          state_d = S_COMMIT;
        end else begin
          cnt_d   = cnt_q + 6'd1;
          state_d = S_MAC_MUL;
        end
      end
      S_COMMIT: state_d = S_IDLE;
      S_READ: begin
        if (sts_i.out_free) begin
          if (cnt_q == 6'(Elems - 1)) begin
            state_d = S_IDLE;
          end else begin
            cnt_d = cnt_q + 6'd1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.act  = DP_NONE;
    cmd_o.cnt  = cnt_q;
    cmd_o.axis = axis_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.act = DP_LATCH;
        end
      end
      S_DECODE: begin
        case (op_e'(sts_i.op))
          OP_IDENT: cmd_o.act = DP_IDENT;
          OP_TRANS: cmd_o.act = DP_T_TRANS;
          OP_SCALE: cmd_o.act = DP_T_SCALE;
          OP_MULT:  cmd_o.act = DP_T_OPND;
          OP_LOAD:  cmd_o.act = DP_LOAD_OP;
          default:  cmd_o.act = DP_NONE;
        endcase
      end
      S_NORM:      cmd_o.act = sts_i.norm_done ? DP_NONE : DP_NORM;
      S_SQ_MUL:    cmd_o.act = DP_SQ_MUL;
      S_SQ_ACC:    cmd_o.act = DP_SQ_ACC;
      S_SQRT_INIT: cmd_o.act = DP_SQRT_INIT;
      S_SQRT:      cmd_o.act = DP_SQRT_STEP;
      S_DIV_INIT:  cmd_o.act = DP_DIV_INIT;
      S_DIV:       cmd_o.act = DP_DIV_STEP;
      S_DIV_DONE:  cmd_o.act = DP_DIV_DONE;
      S_ANG:       cmd_o.act = DP_ANG;
      S_CORDIC:    cmd_o.act = DP_CORDIC;
      S_RP_MUL:    cmd_o.act = DP_RP_MUL;
      S_RP_SAVE:   cmd_o.act = DP_RP_SAVE;
      S_T_ROT:     cmd_o.act = DP_T_ROT;
      S_MAC_MUL:   cmd_o.act = DP_MAC_MUL;
      S_MAC_RND:   cmd_o.act = DP_MAC_RND;
      S_MAC_ACC:   cmd_o.act = DP_MAC_ACC;
      S_COMMIT:    cmd_o.act = DP_COMMIT;
      S_READ:      cmd_o.act = sts_i.out_free ? DP_OUT : DP_NONE;
      default:     cmd_o.act = DP_NONE;
    endcase
  end

endmodule

// ===== rtl/core/tmc_datapath.sv =====
module tmc_datapath import tmc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_item_i,
  input  dp_cmd_t   cmd_i,
  output dp_sts_t   sts_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  in_item_t                   item_q;
  word_t                      cur_q [Elems];
  word_t                      opnd_q [Elems];
  word_t                      t_q [Elems];
  word_t                      r_q [Elems];
  logic signed [32:0]         v_q [Axes];
  logic signed [31:0]         u_q [Axes];
  logic [63:0]                sum_q;
  logic [63:0]                sq_n_q;
  logic [34:0]                sq_rem_q;
  logic [31:0]                root_q;
  logic [61:0]                dnum_q;
  logic [32:0]                drem_q;
  logic signed [35:0]         ang_q;
  logic                       flip_q;
  logic signed [33:0]         cx_q, cy_q;
  logic signed [ProdBits-1:0] prod_q;
  logic signed [MulBits-1:0]  rp_q [RotProducts];
  word_t                      wq_q, acc_q;
  logic                       out_valid_q;
  out_item_t                  out_item_q;

  logic [1:0]                 k_idx, row_idx, col_idx;
  logic [3:0]                 cur_idx;
  word_t                      cur_rd, t_rd, acc_new;
  logic signed [MulBits-1:0]  ma, mb, c_val, s_val, tt_val;
  logic signed [ProdBits-1:0] prod_d;
  logic                       out_free;
  logic [34:0]                sq_sh, sq_trial;
  logic [32:0]                div_sh;
  logic [31:0]                div_mag;
  logic [4:0]                 cord_i;
  logic signed [35:0]         cord_at;
  logic                       v_small;

  function automatic word_t rot_elem(logic signed [MulBits-1:0] a,
                                     logic signed [MulBits-1:0] b);
    logic signed [35:0] s;
    s = 36'(a) + 36'(b) + (36'sd1 <<< (RotShift - 1));
    s = s >>> RotShift;
    return s[WordBits-1:0];
  endfunction

  function automatic logic signed [MulBits-1:0] ext_u(logic signed [31:0] u);
    return {{(MulBits-32){u[31]}}, u};
  endfunction

  assign k_idx   = cmd_i.cnt[1:0];
  assign row_idx = cmd_i.cnt[3:2];
  assign col_idx = cmd_i.cnt[5:4];
  assign cur_idx = (cmd_i.act == DP_OUT) ? cmd_i.cnt[3:0] : {k_idx, row_idx};
  assign cur_rd  = cur_q[cur_idx];
  assign t_rd    = t_q[{col_idx, k_idx}];
  assign acc_new = wadd_sat((k_idx == 2'd0) ? word_t'(0) : acc_q, wq_q);

  assign c_val  = flip_q ? -cx_q : cx_q;
  assign s_val  = flip_q ? -cy_q : cy_q;
  assign tt_val = Q30One - c_val;

  assign v_small = (v_q[0] < NormLimit) && (v_q[0] > -NormLimit) &&
                   (v_q[1] < NormLimit) && (v_q[1] > -NormLimit) &&
                   (v_q[2] < NormLimit) && (v_q[2] > -NormLimit);

  assign out_free = !out_valid_q || out_ready_i;

  assign sts_o.op        = item_q.operation;
  assign sts_o.axis_zero = (item_q.arg_x == '0) && (item_q.arg_y == '0) &&
                           (item_q.arg_z == '0);
  assign sts_o.norm_done = !v_small;
  assign sts_o.out_free  = out_free;

  assign sq_sh    = {sq_rem_q[32:0], sq_n_q[63:62]};
  assign sq_trial = {1'b0, root_q, 2'b01};
  assign div_sh   = {drem_q[31:0], dnum_q[61]};
  assign div_mag  = v_q[cmd_i.axis][32] ? 32'(-v_q[cmd_i.axis]) : v_q[cmd_i.axis][31:0];
  assign cord_i   = cmd_i.cnt[4:0];
  assign cord_at  = $signed({6'd0, atan_q30(cord_i)});

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.act)
      DP_SQ_MUL: begin
        ma = MulBits'(v_q[cmd_i.cnt[1:0]]);
        mb = MulBits'(v_q[cmd_i.cnt[1:0]]);
      end
      DP_RP_MUL: begin
        case (cmd_i.cnt[3:0])
          4'd0:    begin ma = tt_val;   mb = ext_u(u_q[0]); end
          4'd1:    begin ma = tt_val;   mb = ext_u(u_q[1]); end
          4'd2:    begin ma = tt_val;   mb = ext_u(u_q[2]); end
          4'd3:    begin ma = s_val;    mb = ext_u(u_q[0]); end
          4'd4:    begin ma = s_val;    mb = ext_u(u_q[1]); end
          4'd5:    begin ma = s_val;    mb = ext_u(u_q[2]); end
          4'd6:    begin ma = rp_q[0];  mb = ext_u(u_q[0]); end
          4'd7:    begin ma = rp_q[0];  mb = ext_u(u_q[1]); end
          4'd8:    begin ma = rp_q[0];  mb = ext_u(u_q[2]); end
          4'd9:    begin ma = rp_q[1];  mb = ext_u(u_q[1]); end
          4'd10:   begin ma = rp_q[1];  mb = ext_u(u_q[2]); end
          4'd11:   begin ma = rp_q[2];  mb = ext_u(u_q[2]); end
          default: begin ma = '0;       mb = '0; end
        endcase
      end
      DP_MAC_MUL: begin
        ma = MulBits'(cur_rd);
        mb = MulBits'(t_rd);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    prod_d = ma * mb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Elems; i++) begin
        cur_q[i]  <= (i % 5 == 0) ? WordOne : word_t'(0);
        opnd_q[i] <= (i % 5 == 0) ? WordOne : word_t'(0);
      end
      out_valid_q <= 1'b0;
    end else begin
      case (cmd_i.act)
        DP_IDENT: begin
          for (int i = 0; i < Elems; i++) begin
            cur_q[i] <= (i % 5 == 0) ? WordOne : word_t'(0);
          end
        end
        DP_LOAD_OP: opnd_q[item_q.load_index] <= item_q.load_value;
        DP_COMMIT: begin
          for (int i = 0; i < Elems; i++) begin
            cur_q[i] <= r_q[i];
          end
        end
        default: begin
        end
      endcase
      if (cmd_i.act == DP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (cmd_i.act)
      DP_LATCH: begin
        item_q <= in_item_i;
        v_q[0] <= {in_item_i.arg_x[31], in_item_i.arg_x};
        v_q[1] <= {in_item_i.arg_y[31], in_item_i.arg_y};
        v_q[2] <= {in_item_i.arg_z[31], in_item_i.arg_z};
        sum_q  <= '0;
        ang_q  <= {{2{in_item_i.angle[19]}}, in_item_i.angle, 14'd0};
        flip_q <= 1'b0;
      end
      DP_T_TRANS, DP_T_SCALE: begin
        for (int i = 0; i < Elems; i++) begin
          t_q[i] <= (i % 5 == 0) ? WordOne : word_t'(0);
        end
        if (cmd_i.act == DP_T_TRANS) begin
          t_q[12] <= item_q.arg_x;
          t_q[13] <= item_q.arg_y;
          t_q[14] <= item_q.arg_z;
        end else begin
          t_q[0]  <= item_q.arg_x;
          t_q[5]  <= item_q.arg_y;
          t_q[10] <= item_q.arg_z;
        end
      end
      DP_T_OPND: begin
        for (int i = 0; i < Elems; i++) begin
          t_q[i] <= opnd_q[i];
        end
      end
      DP_NORM: begin
        for (int i = 0; i < Axes; i++) begin
          v_q[i] <= v_q[i] <<< 1;
        end
      end
      DP_SQ_ACC: sum_q <= sum_q + prod_q[63:0];
      DP_SQRT_INIT: begin
        sq_n_q   <= sum_q;
        sq_rem_q <= '0;
        root_q   <= '0;
      end
      DP_SQRT_STEP: begin
        sq_n_q <= {sq_n_q[61:0], 2'b00};
        if (sq_sh >= sq_trial) begin
          sq_rem_q <= sq_sh - sq_trial;
          root_q   <= {root_q[30:0], 1'b1};
        end else begin
          sq_rem_q <= sq_sh;
          root_q   <= {root_q[30:0], 1'b0};
        end
      end
      DP_DIV_INIT: begin
        dnum_q <= {div_mag, 30'd0};
        drem_q <= '0;
      end
      DP_DIV_STEP: begin
        if (div_sh >= {1'b0, root_q}) begin
          drem_q <= div_sh - {1'b0, root_q};
          dnum_q <= {dnum_q[60:0], 1'b1};
        end else begin
          drem_q <= div_sh;
          dnum_q <= {dnum_q[60:0], 1'b0};
        end
      end
      DP_DIV_DONE: begin
        u_q[cmd_i.axis] <= v_q[cmd_i.axis][32] ? -$signed(dnum_q[31:0])
                                               : $signed(dnum_q[31:0]);
      end
      DP_ANG: begin
        case (cmd_i.cnt[1:0])
          2'd0: begin
            cx_q <= CordicK;
            cy_q <= '0;
            if (ang_q >= TwoPiQ30) begin
              ang_q <= ang_q - TwoPiQ30;
            end else if (ang_q <= -TwoPiQ30) begin
              ang_q <= ang_q + TwoPiQ30;
            end
          end
          2'd1: begin
            if (ang_q > PiQ30) begin
              ang_q <= ang_q - TwoPiQ30;
            end else if (ang_q < -PiQ30) begin
              ang_q <= ang_q + TwoPiQ30;
            end
          end
          default: begin
            if (ang_q > HalfPiQ30) begin
              ang_q  <= ang_q - PiQ30;
              flip_q <= 1'b1;
            end else if (ang_q < -HalfPiQ30) begin
              ang_q  <= ang_q + PiQ30;
              flip_q <= 1'b1;
            end
          end
        endcase
      end
      DP_CORDIC: begin
        if (!ang_q[35]) begin
          cx_q  <= cx_q - (cy_q >>> cord_i);
          cy_q  <= cy_q + (cx_q >>> cord_i);
          ang_q <= ang_q - cord_at;
        end else begin
          cx_q  <= cx_q + (cy_q >>> cord_i);
          cy_q  <= cy_q - (cx_q >>> cord_i);
          ang_q <= ang_q + cord_at;
        end
      end
      DP_RP_SAVE: rp_q[cmd_i.cnt[3:0]] <= prod_q[63:30];
      DP_T_ROT: begin
        for (int i = 0; i < Elems; i++) begin
          t_q[i] <= word_t'(0);
        end
        t_q[0]  <= rot_elem(rp_q[6], c_val);
        t_q[1]  <= rot_elem(rp_q[7], rp_q[5]);
        t_q[2]  <= rot_elem(rp_q[8], -rp_q[4]);
        t_q[4]  <= rot_elem(rp_q[7], -rp_q[5]);
        t_q[5]  <= rot_elem(rp_q[9], c_val);
        t_q[6]  <= rot_elem(rp_q[10], rp_q[3]);
        t_q[8]  <= rot_elem(rp_q[8], rp_q[4]);
        t_q[9]  <= rot_elem(rp_q[10], -rp_q[3]);
        t_q[10] <= rot_elem(rp_q[11], c_val);
        t_q[15] <= WordOne;
      end
      DP_MAC_RND: wq_q <= wmul_round(prod_q);
      DP_MAC_ACC: begin
        acc_q <= acc_new;
        if (k_idx == 2'd3) begin
          r_q[{col_idx, row_idx}] <= acc_new;
        end
      end
      DP_OUT: begin
        out_item_q.element_index <= cmd_i.cnt[3:0];
        out_item_q.element_value <= cur_rd;
        out_item_q.last          <= (cmd_i.cnt[3:0] == 4'(Elems - 1));
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== rtl/core/transform_matrix_composer_top.sv =====
// Channel  | Signals                            | Direction
// in       | in_valid_i, in_ready_o, in_item_i  | operation items into the block
// out      | out_valid_o, out_ready_i, out_item_o | matrix elements of a read-out
//
// One item at a time: translate, scale and operand multiply run 64
// multiply-accumulates on the one shared multiplier, rotation a shift
// search, square root, three 62-step divides, CORDIC, then the product.
// A read-out sends the 16 matrix elements and is held by any output stalls.
// Reset sets both matrices to identity; an output stall holds only read-outs.
module transform_matrix_composer_top import tmc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  tmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tmc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== rtl/core/tmc_checker.sv =====
module tmc_checker import tmc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("Output transfer dropped or changed while stalled.");

  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.last == (out_item_o.element_index == 4'd15)))
    else $error("Last flag does not match the final element.");

  a_busy_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last |-> !in_ready_o)
    else $error("Input taken in the middle of a read-out.");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Input ready right after a transfer.");

endmodule

bind transform_matrix_composer_top tmc_checker u_checker (.*);
